FILE: hw/rtl/tea_pkg.sv
// Shared types and constants for the TEA cipher round chain.
`default_nettype none

package tea_pkg;

    // Round constant added to the running sum once per full round
    localparam logic [31:0] TEA_DELTA = 32'h9E3779B9;

    // Mode codes carried with every beat
    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    // Key phase: which key pair a half round uses
    localparam logic KPH_K01 = 1'b0;
    localparam logic KPH_K23 = 1'b1;

    // Four key words as loaded from the register file
    typedef struct packed {
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
        logic [31:0] k3;
    } t_key_set;

    // Payload that moves from one cell to the next
    typedef struct packed {
        logic        mode;    // MODE_ENC or MODE_DEC
        logic        kphase;  // key pair used by the next half round
        logic [31:0] a;       // half updated by the next half round
        logic [31:0] b;       // half fed into the mix function
        logic [31:0] sum;     // running delta sum
    } t_tea_beat;

endpackage

`default_nettype wire

FILE: hw/rtl/tea_block_cipher.sv
// TEA block cipher top level: key registers, half-round cell chain, output skid.
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  -----------------------
//  in        sink       i_in_valid / o_in_stall    i_mode, i_block_in
//  out       source     o_out_valid / i_out_stall  o_block_out
//  cfg       sink       APB psel/penable/pready    paddr, pwdata, prdata
//
//  Each block passes 2*ROUNDS half-round cells and one output register;
//  the chain accepts one block per cycle while o_in_stall is low.
//  The chain moves as a whole; a skid register behind it catches the beat
//  that arrives while the output is stalled, and o_in_stall is that register.
//  Reset clears all valid bits and the key words; no clearing pass.
`default_nettype none

module tea_block_cipher #(
    parameter int ROUNDS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input block channel
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_mode,
    input  wire  [63:0] i_block_in,
    // result channel
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [63:0] o_block_out,
    // configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tea_pkg::*;

    localparam int CELLS = 2 * ROUNDS;
    localparam logic [63:0] DEC_SUM_WIDE = 64'(TEA_DELTA) * 64'(ROUNDS);
    localparam logic [31:0] DEC_SUM = DEC_SUM_WIDE[31:0];

    // Register indexes on the configuration port
    localparam logic [1:0] REG_KEY0 = 2'd0;
    localparam logic [1:0] REG_KEY1 = 2'd1;
    localparam logic [1:0] REG_KEY2 = 2'd2;
    localparam logic [1:0] REG_KEY3 = 2'd3;

    t_key_set    r_key;
    logic        w_cfg_wr;
    logic [1:0]  w_reg_idx;

    logic        w_en;
    logic        w_valid [0:CELLS];
    t_tea_beat   w_beat  [0:CELLS];
    logic [63:0] w_tail_block;
    logic        w_take;

    logic        r_skid_valid;
    logic [63:0] r_skid_block;

    // Configuration port
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_KEY0: r_key.k0 <= pwdata;
                REG_KEY1: r_key.k1 <= pwdata;
                REG_KEY2: r_key.k2 <= pwdata;
                REG_KEY3: r_key.k3 <= pwdata;
                default:  r_key    <= r_key;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_KEY0: prdata = r_key.k0;
            REG_KEY1: prdata = r_key.k1;
            REG_KEY2: prdata = r_key.k2;
            REG_KEY3: prdata = r_key.k3;
            default:  prdata = '0;
        endcase
    end

    // Chain moves whenever the skid register is free
    assign w_en       = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    // Load the head beat; decrypt starts on the right half with keys 2/3
    assign w_valid[0] = i_in_valid;
    always_comb begin
        w_beat[0].mode   = i_mode;
        w_beat[0].kphase = (i_mode == MODE_DEC) ? KPH_K23 : KPH_K01;
        w_beat[0].a      = (i_mode == MODE_DEC) ? i_block_in[31:0] : i_block_in[63:32];
        w_beat[0].b      = (i_mode == MODE_DEC) ? i_block_in[63:32] : i_block_in[31:0];
        w_beat[0].sum    = (i_mode == MODE_DEC) ? DEC_SUM : TEA_DELTA;
    end

    // Row of half-round cells
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        tea_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_key   (r_key),
            .i_valid (w_valid[g]),
            .i_beat  (w_beat[g]),
            .o_valid (w_valid[g+1]),
            .o_beat  (w_beat[g+1])
        );
    end

    // Repack halves at the tail
    assign w_tail_block = (w_beat[CELLS].mode == MODE_DEC)
                        ? {w_beat[CELLS].b, w_beat[CELLS].a}
                        : {w_beat[CELLS].a, w_beat[CELLS].b};

    assign w_take = o_out_valid && !i_out_stall;

    // Output register and skid: hold on stall, drain skid first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_valid[CELLS]) begin
            if (!o_out_valid || w_take) begin
                o_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                o_block_out <= r_skid_block;
            end
        end else if (w_valid[CELLS]) begin
            if (!o_out_valid || w_take) begin
                o_block_out <= w_tail_block;
            end else begin
                r_skid_block <= w_tail_block;
            end
        end
    end

    // A full skid always sits behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> o_out_valid)
        else $error("skid holds a beat while the output register is empty");

    // The skid fills only when a tail beat meets a stalled output
    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(o_out_valid && i_out_stall && w_valid[CELLS]))
        else $error("skid filled without a stalled output and a tail beat");

    // A stalled output keeps the skid beat
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && i_out_stall |=> r_skid_valid && $stable(r_skid_block))
        else $error("skid beat lost while the output was stalled");

endmodule

`default_nettype wire

FILE: hw/rtl/tea_cell.sv
// One TEA half round: mix one half into the other, swap, step the sum at the end of a full round.
`default_nettype none

module tea_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  tea_pkg::t_key_set   i_key,
    input  wire                 i_valid,
    input  tea_pkg::t_tea_beat  i_beat,
    output logic                o_valid,
    output tea_pkg::t_tea_beat  o_beat
);
    import tea_pkg::*;

    logic        r_valid;
    t_tea_beat   r_beat;
    t_tea_beat   n_beat;
    logic [31:0] w_ka;
    logic [31:0] w_kb;
    logic [31:0] w_mix;
    logic [31:0] w_a_upd;
    logic        w_step_sum;

    // Pick the key pair for this half round
    assign w_ka = (i_beat.kphase == KPH_K23) ? i_key.k2 : i_key.k0;
    assign w_kb = (i_beat.kphase == KPH_K23) ? i_key.k3 : i_key.k1;

    // Mix the feed half with the key pair and the running sum
    assign w_mix = (({i_beat.b[27:0], 4'b0000}) + w_ka)
                 ^ (i_beat.b + i_beat.sum)
                 ^ (({5'b00000, i_beat.b[31:5]}) + w_kb);

    // Add on encrypt, subtract on decrypt
    assign w_a_upd = (i_beat.mode == MODE_DEC) ? (i_beat.a - w_mix) : (i_beat.a + w_mix);

    // Step the sum at the end of a full round
    assign w_step_sum = (i_beat.kphase != i_beat.mode);

    // Swap halves so the next cell always updates field a
    always_comb begin
        n_beat        = i_beat;
        n_beat.a      = i_beat.b;
        n_beat.b      = w_a_upd;
        n_beat.kphase = ~i_beat.kphase;
        if (w_step_sum) begin
            n_beat.sum = (i_beat.mode == MODE_DEC) ? (i_beat.sum - TEA_DELTA)
                                                   : (i_beat.sum + TEA_DELTA);
        end
    end

    // Advance the beat when the chain moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

FILE: verif/tea_checker.sv
`timescale 1ns / 1ps
// Checker for the TEA block cipher: tracks the key, predicts each block and compares results.
module tea_checker #(
    parameter int ROUNDS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input block channel
    input  wire         i_in_valid,
    input  wire         i_in_stall,
    input  wire         i_mode,
    input  wire  [63:0] i_block_in,
    // result channel
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  wire  [63:0] i_block_out,
    // configuration port
    input  wire         i_psel,
    input  wire         i_penable,
    input  wire         i_pwrite,
    input  wire         i_pready,
    input  wire  [3:0]  i_paddr,
    input  wire  [31:0] i_pwdata,
    // status toward the testbench top
    output int          o_fail_count,
    output int          o_pending
);
    import tea_pkg::*;

    logic [31:0] key_copy [4];
    logic [63:0] expected_blocks [$];
    int          fail_total;

    // One TEA half-round mix of a 32-bit half
    function automatic logic [31:0] feistel_mix(input logic [31:0] v, input logic [31:0] sum,
                                                input logic [31:0] ka, input logic [31:0] kb);
        return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    endfunction

    // Full TEA transform of one block under the tracked key
    function automatic logic [63:0] tea_cipher_block(input logic mode, input logic [63:0] blk);
        logic [31:0] left;
        logic [31:0] right;
        logic [31:0] sum;
        left  = blk[63:32];
        right = blk[31:0];
        if (mode == MODE_DEC) begin
            sum = 32'(TEA_DELTA * ROUNDS);
            for (int r = 0; r < ROUNDS; r++) begin
                right -= feistel_mix(left, sum, key_copy[2], key_copy[3]);
                left  -= feistel_mix(right, sum, key_copy[0], key_copy[1]);
                sum   -= TEA_DELTA;
            end
        end else begin
            sum = '0;
            for (int r = 0; r < ROUNDS; r++) begin
                sum   += TEA_DELTA;
                left  += feistel_mix(right, sum, key_copy[0], key_copy[1]);
                right += feistel_mix(left, sum, key_copy[2], key_copy[3]);
            end
        end
        return {left, right};
    endfunction

    // Count one failure
    function automatic void note_failure();
        fail_total++;
    endfunction

    // Track key writes, queue predictions, and check result beats in order
    always @(posedge i_clk) begin
        logic [63:0] want;
        if (!i_rst_n) begin
            key_copy <= '{default: '0};
            expected_blocks.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                key_copy[i_paddr[3:2]] <= i_pwdata;
            end
            // check the result beat before queuing a new prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_blocks.size() == 0) begin
                    $error("block_out: no result pending, actual %h", i_block_out);
                    note_failure();
                end else begin
                    want = expected_blocks.pop_front();
                    if (want !== i_block_out) begin
                        $error("block_out mismatch: expected %h actual %h", want, i_block_out);
                        note_failure();
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_blocks.push_back(tea_cipher_block(i_mode, i_block_in));
            end
        end
        o_pending    <= expected_blocks.size();
        o_fail_count <= fail_total;
    end

endmodule

FILE: verif/tb_tea_block_cipher.sv
`timescale 1ns / 1ps
// Testbench top for the TEA block cipher: clock, reset, key phases, block stimulus and verdict.
module tb_tea_block_cipher;
    import tea_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int PHASE_BLOCKS   = 340;
    localparam int PHASE_COUNT    = 6;
    localparam int IDLE_PCT       = 36;
    localparam int CALM_FIRST     = 100;
    localparam int CALM_LAST      = 200;

    localparam logic [63:0] EDGE_BLOCKS [6] = '{
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
        64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF
    };

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_mode    = MODE_ENC;
    logic [63:0] in_block   = '0;
    logic        out_stall  = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [3:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic        calm       = 1'b0;
    int          idle_cycles = 0;

    wire         in_stall;
    wire         out_valid;
    wire  [63:0] out_block;
    wire  [31:0] prdata;
    wire         pready;
    int          fail_count;
    int          pending;

    tea_block_cipher u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_mode      (in_mode),
        .i_block_in  (in_block),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_block_out (out_block),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    tea_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_mode       (in_mode),
        .i_block_in   (in_block),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_block_out  (out_block),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Free-running clock, 20 ns period
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stall the result side at random, except during calm stretches
    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // Abort when no beat of any kind moves for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one block beat, idling first at random, and hold until accepted
    task automatic send_block(input logic mode, input logic [63:0] blk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_mode  <= mode;
        in_block <= blk;
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Write all four key words back to back over the config port
    task automatic load_key(input logic [31:0] words [4]);
        for (int idx = 0; idx < 4; idx++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= 4'(idx << 2);
            pwdata  <= words[idx];
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly random blocks, with single-bit and near-extreme patterns mixed in
    function automatic logic [63:0] pick_block();
        case ($urandom_range(9))
            0:       return 64'd1 << $urandom_range(63);
            1:       return ~(64'd1 << $urandom_range(63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Main sequence: reset, then one key setting per phase
    initial begin
        logic [31:0] key_words [4];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            // pick the key for this phase; the first phase keeps the reset key
            case (phase)
                1:       key_words = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
                2:       key_words = '{32'h0011_2233, 32'h4455_6677, 32'h8899_AABB, 32'hCCDD_EEFF};
                4:       key_words = '{32'h0, 32'h0, 32'h0, 32'h0};
                default: key_words = '{$urandom, $urandom, $urandom, $urandom};
            endcase
            if (phase != 0) begin
                load_key(key_words);
            end

            // directed edge blocks in both directions under the extreme keys
            if (phase < 2) begin
                foreach (EDGE_BLOCKS[n]) begin
                    send_block(MODE_ENC, EDGE_BLOCKS[n]);
                    send_block(MODE_DEC, EDGE_BLOCKS[n]);
                end
            end

            // random blocks, with one calm stretch per phase
            for (int n = 0; n < PHASE_BLOCKS; n++) begin
                calm <= (n >= CALM_FIRST) && (n < CALM_LAST);
                send_block($urandom_range(1) ? MODE_DEC : MODE_ENC, pick_block());
            end
            calm <= 1'b0;
            drain_results();
        end

        // let any stray result surface before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
